// ===== rtl/srd_pkg.sv =====
// Package with shared constants, codes and helper functions for the reference generator.
package srd_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned FracBitsDef     = 16;

  localparam int unsigned ZW = 64;   // Angle width, 60 fraction bits plus sign and range.
  localparam int unsigned XW = 34;   // CORDIC x and y width, 30 fraction bits.

  localparam logic [63:0] TwoPiQ60     = 64'h6487ED5110B4611A;
  localparam logic [63:0] QuarterPiQ60 = 64'h0C90FDAA22168C23;
  localparam logic [XW-1:0] GainQ30    = XW'(34'h026DD3B6A);

  typedef enum logic [1:0] {
    MODE_REGULATION = 2'd0,
    MODE_TRACKING   = 2'd1,
    MODE_TRAJECTORY = 2'd2,
    MODE_UNUSED     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    WAVE_CONST  = 2'd0,
    WAVE_SINE   = 2'd1,
    WAVE_COSINE = 2'd2,
    WAVE_UNUSED = 2'd3
  } wave_e;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_WAVEFORM  = 3'd1,
    REG_SETPOINT  = 3'd2,
    REG_AMPLITUDE = 3'd3,
    REG_FREQUENCY = 3'd4,
    REG_OFFSET    = 3'd5
  } reg_idx_e;

  // Output selection decided once per item and carried down the pipeline.
  typedef enum logic [1:0] {
    SEL_ZERO     = 2'd0,
    SEL_SETPOINT = 2'd1,
    SEL_SINE     = 2'd2,
    SEL_COSINE   = 2'd3
  } sel_e;

  // Arctangent table entry for CORDIC iteration i, 60 fraction bits.
  function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
    logic signed [ZW-1:0] sum;
    int unsigned          e;
    logic [63:0]          trm;
    sum = '0;
    if (i == 0) begin
      sum = $signed(QuarterPiQ60);
    end else begin
      for (int unsigned k = 0; k < 31; k++) begin
        e = i * (2 * k + 1);
        if (e <= 60) begin
          trm = (64'd1 << (60 - e)) / 64'(2 * k + 1);
          if (k % 2 == 1) sum = sum - $signed(trm);
          else sum = sum + $signed(trm);
        end
      end
    end
    return sum;
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Clamp a coefficient to plus or minus 2^32.
  function automatic logic signed [33:0] clamp_coef(input logic signed [63:0] v);
    logic signed [33:0] r;
    if (v > 64'sd4294967296) r = 34'sd4294967296;
    else if (v < -64'sd4294967296) r = -34'sd4294967296;
    else r = v[33:0];
    return r;
  endfunction

endpackage

// ===== rtl/srd_cordic.sv =====
// Pipelined rotation-mode CORDIC, one iteration per stage, with the quadrant sign applied at the output.
module srd_cordic #(
  parameter int unsigned CORDIC_STAGES = srd_pkg::CordicStagesDef,
  parameter int unsigned TW = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [srd_pkg::ZW-1:0] z_i,
  input  logic                    neg_i,
  input  logic [TW-1:0]           tag_i,
  output logic                    valid_o,
  output logic signed [srd_pkg::XW-1:0] sin_o,
  output logic signed [srd_pkg::XW-1:0] cos_o,
  output logic [TW-1:0]           tag_o
);
  import srd_pkg::*;

  localparam int unsigned N = (CORDIC_STAGES > 60) ? 61 : CORDIC_STAGES;

  logic signed [XW-1:0] x_q [N+1];
  logic signed [XW-1:0] y_q [N+1];
  logic signed [ZW-1:0] z_q [N+1];
  logic [N:0]           v_q;
  logic [N:0]           neg_q;
  logic [TW-1:0]        tag_q [N+1];

  assign x_q[0]   = $signed(GainQ30);
  assign y_q[0]   = '0;
  assign z_q[0]   = z_i;
  assign v_q[0]   = valid_i;
  assign neg_q[0] = neg_i;
  assign tag_q[0] = tag_i;

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [ZW-1:0] AtanI = atan_entry(i);
    logic signed [XW-1:0] x_d, y_d;
    logic signed [ZW-1:0] z_d;
    always_comb begin
      if (!z_q[i][ZW-1]) begin
        x_d = x_q[i] - (y_q[i] >>> i);
        y_d = y_q[i] + (x_q[i] >>> i);
        z_d = z_q[i] - AtanI;
      end else begin
        x_d = x_q[i] + (y_q[i] >>> i);
        y_d = y_q[i] - (x_q[i] >>> i);
        z_d = z_q[i] + AtanI;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]   <= x_d;
        y_q[i+1]   <= y_d;
        z_q[i+1]   <= z_d;
        neg_q[i+1] <= neg_q[i];
        tag_q[i+1] <= tag_q[i];
      end
    end
  end

  assign valid_o = v_q[N];
  assign sin_o   = neg_q[N] ? -y_q[N] : y_q[N];
  assign cos_o   = neg_q[N] ? -x_q[N] : x_q[N];
  assign tag_o   = tag_q[N];

endmodule

// ===== rtl/sinusoid_reference_with_derivatives.sv =====
// Top level of the single-axis sinusoidal reference generator with derivatives.
// One elapsed-time request is accepted per cycle while the output side takes results;
// each result passes through the phase multiply, quotient, remainder and folding stages,
// one CORDIC iteration per stage and the product and output stages. A stall on the
// output freezes the whole pipeline, so nothing is lost or repeated.
module sinusoid_reference_with_derivatives #(
  parameter int unsigned CORDIC_STAGES = srd_pkg::CordicStagesDef,
  parameter int unsigned FRAC_BITS     = srd_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [19:0]        cfg_data_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [31:0]        elapsed_time_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [31:0] position_o,
  output logic signed [31:0] velocity_o,
  output logic signed [31:0] acceleration_o,
  output logic signed [31:0] jerk_o
);
  import srd_pkg::*;

  localparam int unsigned Sh  = 60 - 2 * FRAC_BITS;
  localparam logic [63:0] Tp  = ((TwoPiQ60 >> (Sh - 1)) + 64'd1) >> 1;
  localparam int unsigned PW  = 52;
  localparam logic signed [ZW-1:0] P2 = $signed(Tp << Sh);
  localparam logic signed [ZW-1:0] P1 = P2 >>> 1;
  localparam logic signed [ZW-1:0] PH = P2 >>> 2;

  // Configuration registers.
  mode_e              mode_q;
  wave_e              wave_q;
  logic signed [18:0] setpoint_q, amplitude_q, offset_q;
  logic [19:0]        freq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_REGULATION;
      wave_q      <= WAVE_CONST;
      setpoint_q  <= '0;
      amplitude_q <= '0;
      freq_q      <= '0;
      offset_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODE:      mode_q      <= mode_e'(cfg_data_i[1:0]);
        REG_WAVEFORM:  wave_q      <= wave_e'(cfg_data_i[1:0]);
        REG_SETPOINT:  setpoint_q  <= cfg_data_i[18:0];
        REG_AMPLITUDE: amplitude_q <= cfg_data_i[18:0];
        REG_FREQUENCY: freq_q      <= cfg_data_i;
        REG_OFFSET:    offset_q    <= cfg_data_i[18:0];
        default: ;
      endcase
    end
  end

  // Coefficients depend only on configuration; a registered chain (c1, c2, c3) settles
  // them after a write, long before any item can use them.
  logic signed [33:0] c1_q, c2_q, c3_q;
  always_ff @(posedge clk_i) begin
    c1_q <= clamp_coef((64'(amplitude_q) * $signed({1'b0, freq_q})) >>> FRAC_BITS);
    c2_q <= clamp_coef((64'(c1_q) * $signed({1'b0, freq_q})) >>> FRAC_BITS);
    c3_q <= clamp_coef((64'(c2_q) * $signed({1'b0, freq_q})) >>> FRAC_BITS);
  end

  sel_e sel;
  always_comb begin
    sel = SEL_ZERO;
    if (mode_q == MODE_REGULATION || (mode_q == MODE_TRACKING && wave_q == WAVE_CONST))
      sel = SEL_SETPOINT;
    else if (mode_q == MODE_TRACKING && wave_q == WAVE_SINE)
      sel = SEL_SINE;
    else if (mode_q == MODE_TRACKING && wave_q == WAVE_COSINE)
      sel = SEL_COSINE;
  end

  logic en;
  logic out_v_q;
  assign en      = !out_v_q || ready_i;
  assign ready_o = en;

  // Stage 1: phase product.
  logic        s1_v_q;
  logic [PW-1:0] s1_p_q;
  sel_e        s1_sel_q;
  // Stage 2: quotient estimate from the upper phase bits by a reciprocal multiply.
  logic        sq_v_q;
  logic [PW-1:0] sq_p_q;
  logic [31:0] sq_q_q;
  sel_e        sq_sel_q;
  // Stage 3: remainder modulo 2*pi; the estimate is at most two below the quotient.
  logic        s2_v_q;
  logic [PW-1:0] s2_r_q;
  sel_e        s2_sel_q;
  // Stage 4: folding into the CORDIC range.
  logic        s3_v_q;
  logic signed [ZW-1:0] s3_z_q;
  logic        s3_neg_q;
  sel_e        s3_sel_q;

  localparam int unsigned RcpSh  = 64;
  localparam int unsigned LoBits = 20;
  localparam logic [63:0] Rcp    = (~64'd0) / Tp;
  logic [95:0]   q_prod;
  logic [31:0]   q_est;
  always_comb begin
    q_prod = 96'(s1_p_q[PW-1:LoBits]) * 96'(Rcp);
    q_est  = 32'(q_prod >> (RcpSh - LoBits));
  end

  logic [PW-1:0] rem_est;
  logic [PW+1:0] r0;
  always_comb begin
    r0      = (PW+2)'(sq_p_q - PW'(64'(sq_q_q) * Tp));
    if (r0 >= (PW+2)'(3 * Tp)) rem_est = PW'(r0 - (PW+2)'(3 * Tp));
    else if (r0 >= (PW+2)'(2 * Tp)) rem_est = PW'(r0 - (PW+2)'(2 * Tp));
    else if (r0 >= (PW+2)'(Tp)) rem_est = PW'(r0 - (PW+2)'(Tp));
    else rem_est = PW'(r0);
  end

  logic signed [ZW-1:0] zf;
  logic                 negf;
  always_comb begin
    zf   = $signed(ZW'(s2_r_q) << Sh);
    negf = 1'b0;
    if (zf > P1) zf = zf - P2;
    if (zf > PH) begin
      zf   = zf - P1;
      negf = 1'b1;
    end else if (zf < -PH) begin
      zf   = zf + P1;
      negf = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      sq_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= valid_i;
      sq_v_q <= s1_v_q;
      s2_v_q <= sq_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_p_q   <= PW'(freq_q) * PW'(elapsed_time_i);
      s1_sel_q <= sel;
      sq_p_q   <= s1_p_q;
      sq_q_q   <= q_est;
      sq_sel_q <= s1_sel_q;
      s2_r_q   <= rem_est;
      s2_sel_q <= sq_sel_q;
      s3_z_q   <= zf;
      s3_neg_q <= negf;
      s3_sel_q <= s2_sel_q;
    end
  end

  logic                 cd_v;
  logic signed [XW-1:0] cd_sin, cd_cos;
  logic [1:0]           cd_tag;

  srd_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .TW            (2)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .z_i     (s3_z_q),
    .neg_i   (s3_neg_q),
    .tag_i   (s3_sel_q),
    .valid_o (cd_v),
    .sin_o   (cd_sin),
    .cos_o   (cd_cos),
    .tag_o   (cd_tag)
  );

  // Product stage: four coefficient by trig multiplies. Signs are applied after
  // rounding so that ties round the same way as the unsigned-direction term.
  sel_e cd_sel;
  assign cd_sel = sel_e'(cd_tag);
  logic signed [XW-1:0] g0, g1;
  always_comb begin
    if (cd_sel == SEL_COSINE) begin
      g0 = cd_cos; g1 = cd_sin;
    end else begin
      g0 = cd_sin; g1 = cd_cos;
    end
  end

  logic               m_v_q;
  sel_e               m_sel_q;
  logic signed [67:0] m0_q, m1_q, m2_q, m3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_v_q <= 1'b0;
    else if (en) m_v_q <= cd_v;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_sel_q <= cd_sel;
      m0_q    <= 68'(amplitude_q) * 68'(g0);
      m1_q    <= 68'(c1_q) * 68'(g1);
      m2_q    <= 68'(c2_q) * 68'(g0);
      m3_q    <= 68'(c3_q) * 68'(g1);
    end
  end

  // Rounding, offset, saturation and output register.
  function automatic logic signed [63:0] rnd(input logic signed [67:0] m);
    logic signed [67:0] t;
    t = (m + 68'sd536870912) >>> 30;
    return t[63:0];
  endfunction

  logic signed [31:0] pos_d, vel_d, acc_d, jrk_d;
  always_comb begin
    unique case (m_sel_q)
      SEL_SETPOINT: begin
        pos_d = 32'(setpoint_q); vel_d = '0; acc_d = '0; jrk_d = '0;
      end
      SEL_SINE: begin
        pos_d = sat32(rnd(m0_q) + 64'(offset_q));
        vel_d = sat32(rnd(m1_q));
        acc_d = sat32(-rnd(m2_q));
        jrk_d = sat32(-rnd(m3_q));
      end
      SEL_COSINE: begin
        pos_d = sat32(rnd(m0_q) + 64'(offset_q));
        vel_d = sat32(-rnd(m1_q));
        acc_d = sat32(-rnd(m2_q));
        jrk_d = sat32(rnd(m3_q));
      end
      default: begin
        pos_d = '0; vel_d = '0; acc_d = '0; jrk_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= m_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      position_o     <= pos_d;
      velocity_o     <= vel_d;
      acceleration_o <= acc_d;
      jerk_o         <= jrk_d;
    end
  end
  assign valid_o = out_v_q;

  // A held result stays put while the consumer stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(position_o) && $stable(jerk_o)))
    else $error("output changed during stall");
  // An empty output register never blocks the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (!valid_o) |-> ready_o)
    else $error("not ready with empty output");
  // An accepted request is in stage one next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (valid_i && ready_o) |=> s1_v_q)
    else $error("request lost at entry");

endmodule

// ===== verif/srd_checker.sv =====
// Checker for the sinusoid reference generator: mirrors the registers, predicts and compares.
`timescale 1ns / 100ps
module srd_checker #(
  parameter int unsigned CORDIC_STAGES = srd_pkg::CordicStagesDef,
  parameter int unsigned FRAC_BITS     = srd_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i,
  input  logic        valid_i,
  input  logic        ready_o,
  input  logic [31:0] elapsed_time_i,
  input  logic        valid_o,
  input  logic        ready_i,
  input  logic [31:0] position_o,
  input  logic [31:0] velocity_o,
  input  logic [31:0] acceleration_o,
  input  logic [31:0] jerk_o,
  output int          errors_o,
  output int          pending_o
);
  import srd_pkg::*;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] acc;
    logic [31:0] jrk;
  } sample_t;

  localparam longint CoefLimit = 64'sd4294967296;

  mode_e       mode_q;
  wave_e       wave_q;
  logic [18:0] setpoint_q;
  logic [18:0] amplitude_q;
  logic [19:0] frequency_q;
  logic [18:0] offset_q;
  sample_t     expected_q[$];
  int          errors;

  assign errors_o  = errors;
  assign pending_o = expected_q.size();

  function automatic longint arctan_q60(int unsigned i);
    longint sum;
    int unsigned e;
    sum = 0;
    if (i == 0) return longint'(QuarterPiQ60);
    for (int unsigned k = 0; i * (2 * k + 1) <= 60; k++) begin
      e = i * (2 * k + 1);
      if (k % 2 == 1) sum -= longint'((64'd1 << (60 - e)) / 64'(2 * k + 1));
      else sum += longint'((64'd1 << (60 - e)) / 64'(2 * k + 1));
    end
    return sum;
  endfunction

  function automatic longint clamp_to(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic logic [31:0] sat32_of(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Product of a coefficient and a Q30 trig value, rounded half up back to QF.
  function automatic longint scaled(longint c, longint g);
    return (c * g + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic sample_t reference_at(logic [31:0] t);
    int unsigned sh;
    logic [63:0] tp, phase;
    longint p2, p1, ph, z, x, y, dx, dy, s, c, a, b, w, c1, c2, c3;
    longint pos, vel, acc, jrk;
    bit neg;
    sample_t r;
    pos = 0; vel = 0; acc = 0; jrk = 0;
    if (mode_q == MODE_REGULATION || (mode_q == MODE_TRACKING && wave_q == WAVE_CONST)) begin
      pos = longint'($signed(setpoint_q));
    end else if (mode_q == MODE_TRACKING && (wave_q == WAVE_SINE || wave_q == WAVE_COSINE)) begin
      a = longint'($signed(amplitude_q));
      b = longint'($signed(offset_q));
      w = longint'({44'd0, frequency_q});
      // Phase reduction modulo 2*pi, then folding into the CORDIC range.
      sh = 60 - 2 * FRAC_BITS;
      tp = ((TwoPiQ60 >> (sh - 1)) + 1) >> 1;
      phase = {44'd0, frequency_q} * {32'd0, t};
      p2 = longint'(tp << sh);
      p1 = p2 / 2;
      ph = p2 / 4;
      z = longint'((phase % tp) << sh);
      neg = 1'b0;
      if (z > p1) z -= p2;
      if (z > ph) begin
        z -= p1;
        neg = 1'b1;
      end else if (z < -ph) begin
        z += p1;
        neg = 1'b1;
      end
      x = longint'(GainQ30);
      y = 0;
      for (int unsigned i = 0; i < CORDIC_STAGES && i <= 60; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= arctan_q60(i);
        end else begin
          x += dx; y -= dy; z += arctan_q60(i);
        end
      end
      s = neg ? -y : y;
      c = neg ? -x : x;
      c1 = clamp_to((a * w) >>> FRAC_BITS, CoefLimit);
      c2 = clamp_to((c1 * w) >>> FRAC_BITS, CoefLimit);
      c3 = clamp_to((c2 * w) >>> FRAC_BITS, CoefLimit);
      if (wave_q == WAVE_SINE) begin
        pos = scaled(a, s) + b;
        vel = scaled(c1, c);
        acc = -scaled(c2, s);
        jrk = -scaled(c3, c);
      end else begin
        pos = scaled(a, c) + b;
        vel = -scaled(c1, s);
        acc = -scaled(c2, c);
        jrk = scaled(c3, s);
      end
    end
    r.pos = sat32_of(pos);
    r.vel = sat32_of(vel);
    r.acc = sat32_of(acc);
    r.jrk = sat32_of(jrk);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t got, want;
    if (!rst_ni) begin
      mode_q      <= MODE_REGULATION;
      wave_q      <= WAVE_CONST;
      setpoint_q  <= '0;
      amplitude_q <= '0;
      frequency_q <= '0;
      offset_q    <= '0;
      errors      <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_MODE:      mode_q      <= mode_e'(cfg_data_i[1:0]);
          REG_WAVEFORM:  wave_q      <= wave_e'(cfg_data_i[1:0]);
          REG_SETPOINT:  setpoint_q  <= cfg_data_i[18:0];
          REG_AMPLITUDE: amplitude_q <= cfg_data_i[18:0];
          REG_FREQUENCY: frequency_q <= cfg_data_i;
          REG_OFFSET:    offset_q    <= cfg_data_i[18:0];
          default: ;
        endcase
      end
      if (valid_i && ready_o) expected_q.push_back(reference_at(elapsed_time_i));
      if (valid_o && ready_i) begin
        got = '{position_o, velocity_o, acceleration_o, jerk_o};
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("Unexpected result: %h", got);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            if (errors < 10)
              $display("Mismatch: pos %h/%h vel %h/%h acc %h/%h jerk %h/%h (expected/actual)",
                       want.pos, got.pos, want.vel, got.vel, want.acc, got.acc,
                       want.jrk, got.jrk);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_sinusoid_reference_with_derivatives.sv =====
// Stimulus and verdict for the sinusoid reference generator testbench.
`timescale 1ns / 100ps
module tb_sinusoid_reference_with_derivatives;
  import srd_pkg::*;

  localparam int unsigned Latency   = CordicStagesDef + 6;
  localparam int          CycleLimit = 400000;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [19:0] cfg_data;
  logic        valid_in, ready_out, valid_out, ready_in;
  logic [31:0] elapsed_time;
  logic [31:0] position, velocity, acceleration, jerk;
  int          errors, pending, cycles, idle_mode;

  sinusoid_reference_with_derivatives i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .valid_i(valid_in), .ready_o(ready_out), .elapsed_time_i(elapsed_time),
    .valid_o(valid_out), .ready_i(ready_in),
    .position_o(position), .velocity_o(velocity),
    .acceleration_o(acceleration), .jerk_o(jerk)
  );

  srd_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .valid_i(valid_in), .ready_o(ready_out), .elapsed_time_i(elapsed_time),
    .valid_o(valid_out), .ready_i(ready_in),
    .position_o(position), .velocity_o(velocity),
    .acceleration_o(acceleration), .jerk_o(jerk),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver stalls according to the current idling phase.
  always @(posedge clk) begin
    case (idle_mode)
      2: ready_in <= ($urandom_range(99) >= 59);
      3: ready_in <= ($urandom_range(99) >= 6);
      default: ready_in <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [19:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic write_raw(logic [2:0] idx, logic [19:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic drain_then_idle();
    cfg_we   <= 1'b0;
    valid_in <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic send_request(logic [31:0] t);
    int gap;
    gap = 0;
    if (idle_mode == 1 && $urandom_range(99) < 59) gap = $urandom_range(1, 4);
    if (idle_mode == 3 && $urandom_range(99) < 6) gap = 1;
    if (gap > 0) begin
      valid_in <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_we       <= 1'b0;
    valid_in     <= 1'b1;
    elapsed_time <= t;
    do @(posedge clk); while (!ready_out);
  endtask

  function automatic logic [19:0] pick_signed(int unsigned lim);
    case ($urandom_range(5))
      0: return 20'(lim);
      1: return 20'(-int'(lim));
      2: return 20'($urandom());
      default: return 20'($urandom_range(2 * lim) - int'(lim));
    endcase
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(7))
      0: return 32'hFFFFFFFF;
      1: return $urandom_range(15);
      2: return $urandom_range(32'h000FFFFF);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [19:0] freq;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    valid_in     = 1'b0;
    ready_in     = 1'b1;
    elapsed_time = '0;
    cycles       = 0;
    idle_mode    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: regulation after reset, then every mode and waveform at the extremes.
    send_request(32'h0);
    send_request(32'hFFFFFFFF);
    drain_then_idle();
    write_reg(REG_SETPOINT, 20'h20000);
    write_reg(REG_AMPLITUDE, 20'h20000);
    write_reg(REG_FREQUENCY, 20'hA0000);
    write_reg(REG_OFFSET, 20'h30000);
    write_raw(3'd6, 20'hFFFFF);
    write_raw(3'd7, 20'h12345);
    for (int m = 0; m < 4; m++) begin
      for (int wv = 0; wv < 4; wv++) begin
        drain_then_idle();
        write_reg(REG_MODE, 20'(m));
        write_reg(REG_WAVEFORM, 20'(wv));
        send_request(wv[0] ? 32'hFFFFFFFF : 32'h00012345);
      end
    end
    // A negative amplitude with the largest frequency drives the coefficient chain.
    drain_then_idle();
    write_reg(REG_AMPLITUDE, 20'hE0000);
    write_reg(REG_FREQUENCY, 20'hFFFFF);
    write_reg(REG_OFFSET, 20'hD0000);
    write_reg(REG_SETPOINT, 20'hE0000);
    write_reg(REG_MODE, 20'(MODE_TRACKING));
    write_reg(REG_WAVEFORM, 20'(WAVE_SINE));
    send_request(32'h0);
    send_request(32'hFFFFFFFF);
    send_request(32'h80000000);

    // Random phases, each with a fresh setting and one idling pattern.
    for (int ph = 0; ph < 32; ph++) begin
      drain_then_idle();
      idle_mode = ph % 4;
      write_reg(REG_MODE, ($urandom_range(9) < 7) ? 20'(MODE_TRACKING) : 20'($urandom()));
      write_reg(REG_WAVEFORM, ($urandom_range(9) < 8) ? 20'($urandom_range(1, 2))
                                                     : 20'($urandom()));
      write_reg(REG_SETPOINT, pick_signed(131072));
      write_reg(REG_AMPLITUDE, pick_signed(131072));
      case ($urandom_range(4))
        0: freq = 20'd655360;
        1: freq = 20'($urandom());
        2: freq = 20'($urandom_range(65536));
        default: freq = 20'($urandom_range(655360));
      endcase
      write_reg(REG_FREQUENCY, freq);
      write_reg(REG_OFFSET, pick_signed(196608));
      for (int n = 0; n < 48; n++) send_request(pick_time());
    end

    drain_then_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/srd_pkg.sv
rtl/srd_cordic.sv
rtl/sinusoid_reference_with_derivatives.sv
verif/srd_checker.sv
verif/tb_sinusoid_reference_with_derivatives.sv
